FILE: src/chlb_pkg.sv
`timescale 1ns / 1ps

package chlb_pkg;

    // Fixed widths of the item and result fields.
    localparam int CMD_W    = 3;
    localparam int HAND_W   = 11;
    localparam int CARD_IN_W = 6;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 13;

    // Default sizes handed to the top level.
    localparam int DEF_MAX_ITEMS = 2048;
    localparam int DEF_NUM_CARDS = 52;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_OFF  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_LIST = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNBUILT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_ZERO,
        S_IT_RD,
        S_CN_RD0,
        S_CN_WR0,
        S_CN_RD1,
        S_CN_WR1,
        S_PF_RD,
        S_PF_WR
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_EXEC,
        DP_RD_ISSUE,
        DP_RD_RESULT,
        DP_BUILD_START,
        DP_ZERO,
        DP_IT_RD,
        DP_CN_RD,
        DP_CN_WR,
        DP_PF_RD,
        DP_PF_WR,
        DP_BUILD_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel_second;
        logic   scatter;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_off_ok;
        logic rd_list_ok;
        logic card_last;
        logic items_done;
    } t_dp_stat;

endpackage

FILE: src/card_holder_list_builder.sv
`timescale 1ns / 1ps

// Card bucket index builder. Issue a command by raising start while busy is
// low; the single result item of every command appears on o_status and
// o_read_value for exactly one cycle, marked by o_done, and cannot be held
// off, so capture it when o_done is high. Clear, add, the spare codes and
// any command that is refused (full store, bad card, read before build,
// index out of range) give their result in the cycle after acceptance and
// the block takes a new command in that same cycle. A successful read of an
// offset or a list entry keeps busy high while the memory is read, and its
// result is then registered. A build keeps busy high while it clears the
// per-card counters, walks the stored items to count them (reading each
// item and doing a read-modify-write of its two counters in the counter
// memory), forms the running offsets card by card, and walks the items again
// to scatter them. The result of a build carries the total number of list
// entries. No clearing pass runs after reset: the counters are cleared at
// the start of every build.

module card_holder_list_builder #(
    parameter int MAX_ITEMS = chlb_pkg::DEF_MAX_ITEMS,
    parameter int NUM_CARDS = chlb_pkg::DEF_NUM_CARDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [chlb_pkg::CMD_W-1:0]     i_cmd,
    input  logic [chlb_pkg::HAND_W-1:0]    i_hand_id,
    input  logic [chlb_pkg::CARD_IN_W-1:0] i_card_first,
    input  logic [chlb_pkg::CARD_IN_W-1:0] i_card_second,
    input  logic [chlb_pkg::INDEX_W-1:0]   i_read_index,
    output logic                           o_done,
    output logic [chlb_pkg::STATUS_W-1:0]  o_status,
    output logic [chlb_pkg::VALUE_W-1:0]   o_read_value
);
    import chlb_pkg::*;

    // Commands from the controller and status back from the datapath.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller sequences the build walks and decides, from the
    // datapath's range checks, whether a read goes to memory or is refused.
    chlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd_code (i_cmd),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_busy     (busy)
    );

    // The datapath holds the item store, the counter and offset memories,
    // the bucket list and the result register.
    chlb_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .NUM_CARDS (NUM_CARDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_cmd_code    (i_cmd),
        .i_hand_id     (i_hand_id),
        .i_card_first  (i_card_first),
        .i_card_second (i_card_second),
        .i_read_index  (i_read_index),
        .o_stat        (dp_stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_read_value  (o_read_value)
    );

endmodule

FILE: src/chlb_ctrl.sv
`timescale 1ns / 1ps

module chlb_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [chlb_pkg::CMD_W-1:0] i_cmd_code,
    input  chlb_pkg::t_dp_stat         i_stat,
    output chlb_pkg::t_dp_cmd          o_cmd,
    output logic                       o_busy
);
    import chlb_pkg::*;

    t_state r_state, n_state;
    logic   r_scatter, n_scatter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_scatter <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scatter <= n_scatter;
        end
    end

    // Next state.
    always_comb begin
        n_state   = r_state;
        n_scatter = r_scatter;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd_code == CMD_BUILD) begin
                        n_state   = S_ZERO;
                        n_scatter = 1'b0;
                    end else if ((i_cmd_code == CMD_READ_OFF && i_stat.rd_off_ok) ||
                                 (i_cmd_code == CMD_READ_LIST && i_stat.rd_list_ok)) begin
                        n_state = S_RD_WAIT;
                    end
                end
            end
            S_RD_WAIT: n_state = S_IDLE;
            S_ZERO: begin
                if (i_stat.card_last) begin
                    n_state = S_IT_RD;
                end
            end
            S_IT_RD: begin
                if (!i_stat.items_done) begin
                    n_state = S_CN_RD0;
                end else if (r_scatter) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PF_RD;
                end
            end
            S_CN_RD0: n_state = S_CN_WR0;
            S_CN_WR0: n_state = S_CN_RD1;
            S_CN_RD1: n_state = S_CN_WR1;
            S_CN_WR1: n_state = S_IT_RD;
            S_PF_RD:  n_state = S_PF_WR;
            S_PF_WR: begin
                if (i_stat.card_last) begin
                    n_state   = S_IT_RD;
                    n_scatter = 1'b1;
                end else begin
                    n_state = S_PF_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd.op         = DP_NONE;
        o_cmd.sel_second = 1'b0;
        o_cmd.scatter    = r_scatter;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd_code == CMD_BUILD) begin
                        o_cmd.op = DP_BUILD_START;
                    end else if ((i_cmd_code == CMD_READ_OFF && i_stat.rd_off_ok) ||
                                 (i_cmd_code == CMD_READ_LIST && i_stat.rd_list_ok)) begin
                        o_cmd.op = DP_RD_ISSUE;
                    end else begin
                        o_cmd.op = DP_EXEC;
                    end
                end
            end
            S_RD_WAIT: o_cmd.op = DP_RD_RESULT;
            S_ZERO:    o_cmd.op = DP_ZERO;
            S_IT_RD: begin
                if (!i_stat.items_done) begin
                    o_cmd.op = DP_IT_RD;
                end else if (r_scatter) begin
                    o_cmd.op = DP_BUILD_DONE;
                end
            end
            S_CN_RD0: o_cmd.op = DP_CN_RD;
            S_CN_WR0: o_cmd.op = DP_CN_WR;
            S_CN_RD1: begin
                o_cmd.op         = DP_CN_RD;
                o_cmd.sel_second = 1'b1;
            end
            S_CN_WR1: begin
                o_cmd.op         = DP_CN_WR;
                o_cmd.sel_second = 1'b1;
            end
            S_PF_RD: o_cmd.op = DP_PF_RD;
            S_PF_WR: o_cmd.op = DP_PF_WR;
            default: o_cmd.op = DP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: src/chlb_dp.sv
`timescale 1ns / 1ps

module chlb_dp #(
    parameter int MAX_ITEMS = chlb_pkg::DEF_MAX_ITEMS,
    parameter int NUM_CARDS = chlb_pkg::DEF_NUM_CARDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  chlb_pkg::t_dp_cmd              i_cmd,
    input  logic [chlb_pkg::CMD_W-1:0]     i_cmd_code,
    input  logic [chlb_pkg::HAND_W-1:0]    i_hand_id,
    input  logic [chlb_pkg::CARD_IN_W-1:0] i_card_first,
    input  logic [chlb_pkg::CARD_IN_W-1:0] i_card_second,
    input  logic [chlb_pkg::INDEX_W-1:0]   i_read_index,
    output chlb_pkg::t_dp_stat             o_stat,
    output logic                           o_done,
    output logic [chlb_pkg::STATUS_W-1:0]  o_status,
    output logic [chlb_pkg::VALUE_W-1:0]   o_read_value
);
    import chlb_pkg::*;

    localparam int LIST_DEPTH = 2 * MAX_ITEMS;
    localparam int AW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int CW     = $clog2(NUM_CARDS);
    localparam int OW     = $clog2(NUM_CARDS + 1);
    localparam int LW     = $clog2(LIST_DEPTH);
    localparam int OFF_W  = $clog2(LIST_DEPTH + 1);
    localparam int ITEM_W = HAND_W + 2 * CW;

    // Memories.
    logic [ITEM_W-1:0] m_item [MAX_ITEMS];
    logic [OFF_W-1:0]  m_cnt  [NUM_CARDS];
    logic [OFF_W-1:0]  m_off  [NUM_CARDS + 1];
    logic [HAND_W-1:0] m_list [LIST_DEPTH];

    // Control registers.
    logic [CNT_W-1:0]    r_item_count, n_item_count;
    logic                r_built, n_built;
    logic [OFF_W-1:0]    r_total, n_total;
    logic [OFF_W-1:0]    r_acc, n_acc;
    logic [CW-1:0]       r_idx_c, n_idx_c;
    logic [CNT_W-1:0]    r_idx_i, n_idx_i;
    logic                r_rd_list, n_rd_list;
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VALUE_W-1:0]  r_value, n_value;

    // Registered read data.
    logic [ITEM_W-1:0] r_item_q;
    logic [OFF_W-1:0]  r_cnt_q;
    logic [OFF_W-1:0]  r_off_q;
    logic [HAND_W-1:0] r_list_q;

    // Memory strobes.
    logic              item_we, item_re;
    logic              cnt_we, cnt_re;
    logic [CW-1:0]     cnt_waddr, cnt_raddr;
    logic [OFF_W-1:0]  cnt_wdata;
    logic              off_we, off_re;
    logic [OW-1:0]     off_waddr;
    logic [OFF_W-1:0]  off_wdata;
    logic              list_we, list_re;
    logic [LW-1:0]     list_waddr;

    logic              store_full, card_bad;
    logic [CW-1:0]     card_sel;
    logic [HAND_W-1:0] item_hand;
    logic [OFF_W-1:0]  pf_sum;

    assign store_full = (r_item_count == CNT_W'(MAX_ITEMS));
    assign card_bad   = (32'(i_card_first) >= 32'(NUM_CARDS)) ||
                        (32'(i_card_second) >= 32'(NUM_CARDS));
    assign item_hand  = r_item_q[ITEM_W-1 -: HAND_W];
    assign card_sel   = i_cmd.sel_second ? r_item_q[2*CW-1:CW] : r_item_q[CW-1:0];
    assign pf_sum     = r_acc + r_cnt_q;

    assign o_stat.rd_off_ok  = r_built && (32'(i_read_index) <= 32'(NUM_CARDS));
    assign o_stat.rd_list_ok = r_built && (32'(i_read_index) < 32'(r_total)) &&
                               (32'(i_read_index) < 32'(LIST_DEPTH));
    assign o_stat.card_last  = (r_idx_c == CW'(NUM_CARDS - 1));
    assign o_stat.items_done = (r_idx_i == r_item_count);

    always_comb begin
        n_item_count = r_item_count;
        n_built      = r_built;
        n_total      = r_total;
        n_acc        = r_acc;
        n_idx_c      = r_idx_c;
        n_idx_i      = r_idx_i;
        n_rd_list    = r_rd_list;
        n_done       = 1'b0;
        n_status     = r_status;
        n_value      = r_value;
        item_we      = 1'b0;
        item_re      = 1'b0;
        cnt_we       = 1'b0;
        cnt_re       = 1'b0;
        cnt_waddr    = card_sel;
        cnt_raddr    = card_sel;
        cnt_wdata    = r_cnt_q + OFF_W'(1);
        off_we       = 1'b0;
        off_re       = 1'b0;
        off_waddr    = OW'(r_idx_c) + OW'(1);
        off_wdata    = pf_sum;
        list_we      = 1'b0;
        list_re      = 1'b0;
        list_waddr   = r_cnt_q[LW-1:0];
        unique case (i_cmd.op)
            DP_EXEC: begin
                n_done   = 1'b1;
                n_status = STAT_OK;
                n_value  = '0;
                unique case (i_cmd_code)
                    CMD_CLEAR: begin
                        n_item_count = '0;
                        n_built      = 1'b0;
                    end
                    CMD_ADD: begin
                        if (store_full) begin
                            n_status = STAT_FULL;
                        end else if (card_bad) begin
                            n_status = STAT_RANGE;
                        end else begin
                            item_we      = 1'b1;
                            n_item_count = r_item_count + CNT_W'(1);
                            n_built      = 1'b0;
                        end
                    end
                    CMD_READ_OFF, CMD_READ_LIST: begin
                        n_status = r_built ? STAT_RANGE : STAT_UNBUILT;
                    end
                    default: ;
                endcase
            end
            DP_RD_ISSUE: begin
                n_rd_list = (i_cmd_code == CMD_READ_LIST);
                off_re    = (i_cmd_code == CMD_READ_OFF);
                list_re   = (i_cmd_code == CMD_READ_LIST);
            end
            DP_RD_RESULT: begin
                n_done   = 1'b1;
                n_status = STAT_OK;
                n_value  = r_rd_list ? VALUE_W'(r_list_q) : VALUE_W'(r_off_q);
            end
            DP_BUILD_START: begin
                n_idx_c   = '0;
                n_idx_i   = '0;
                n_acc     = '0;
                off_we    = 1'b1;
                off_waddr = '0;
                off_wdata = '0;
            end
            DP_ZERO: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_idx_c;
                cnt_wdata = '0;
                n_idx_c   = o_stat.card_last ? '0 : r_idx_c + CW'(1);
            end
            DP_IT_RD: begin
                item_re = 1'b1;
            end
            DP_CN_RD: begin
                cnt_re = 1'b1;
            end
            DP_CN_WR: begin
                // Count pass bumps the counter; scatter pass bumps the cursor
                // and drops the hand id into the bucket slot it pointed at.
                cnt_we  = 1'b1;
                list_we = i_cmd.scatter && (32'(r_cnt_q) < 32'(LIST_DEPTH));
                if (i_cmd.sel_second) begin
                    n_idx_i = r_idx_i + CNT_W'(1);
                end
            end
            DP_PF_RD: begin
                cnt_re    = 1'b1;
                cnt_raddr = r_idx_c;
            end
            DP_PF_WR: begin
                off_we    = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = r_idx_c;
                cnt_wdata = r_acc;
                n_acc     = pf_sum;
                if (o_stat.card_last) begin
                    n_idx_c = '0;
                    n_idx_i = '0;
                    n_total = pf_sum;
                end else begin
                    n_idx_c = r_idx_c + CW'(1);
                end
            end
            DP_BUILD_DONE: begin
                n_built  = 1'b1;
                n_done   = 1'b1;
                n_status = STAT_OK;
                n_value  = VALUE_W'(r_total);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
            r_built      <= 1'b0;
            r_total      <= '0;
            r_acc        <= '0;
            r_idx_c      <= '0;
            r_idx_i      <= '0;
            r_rd_list    <= 1'b0;
            r_done       <= 1'b0;
            r_status     <= STAT_OK;
            r_value      <= '0;
        end else begin
            r_item_count <= n_item_count;
            r_built      <= n_built;
            r_total      <= n_total;
            r_acc        <= n_acc;
            r_idx_c      <= n_idx_c;
            r_idx_i      <= n_idx_i;
            r_rd_list    <= n_rd_list;
            r_done       <= n_done;
            r_status     <= n_status;
            r_value      <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_we) begin
            m_item[r_item_count[AW-1:0]] <= {i_hand_id, CW'(i_card_second), CW'(i_card_first)};
        end
        if (item_re) begin
            r_item_q <= m_item[r_idx_i[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_cnt[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_q <= m_cnt[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            m_off[off_waddr] <= off_wdata;
        end
        if (off_re) begin
            r_off_q <= m_off[OW'(i_read_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (list_we) begin
            m_list[list_waddr] <= item_hand;
        end
        if (list_re) begin
            r_list_q <= m_list[LW'(i_read_index)];
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_read_value = r_value;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_item_count) <= 32'(MAX_ITEMS))
        else $error("item count beyond store capacity");

    a_read_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_RD_RESULT) |-> ($past(i_cmd.op) == DP_RD_ISSUE))
        else $error("read result taken without a preceding memory read");

    a_scatter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_CN_WR && i_cmd.scatter) |-> (32'(r_cnt_q) < 32'(LIST_DEPTH)))
        else $error("bucket cursor ran past the list");

    a_build_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_BUILD_DONE) |=> (o_done && o_status == STAT_OK && r_built))
        else $error("build finished without an ok result");
`endif

endmodule

FILE: tb/card_holder_list_builder_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the card bucket index builder.
//
// Every command the bench issues produces exactly one result item, so the
// bench keeps a single queue of expected answers. A command is accepted at
// the rising edge where start is high and busy is low. At that point the
// bench runs its own model of the index (stored hands, per-card tallies,
// running offsets and the scattered bucket list) and queues the answer.
// Results are strobed by o_done for one cycle and cannot be held off. Each
// one is compared, field by field, against the oldest queued answer.

module card_holder_list_builder_test;
    import chlb_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int MAX_ITEMS      = DEF_MAX_ITEMS;
    localparam int NUM_CARDS      = DEF_NUM_CARDS;
    localparam int LIST_DEPTH     = 2 * MAX_ITEMS;
    localparam int HAND_MAX       = (1 << HAND_W) - 1;
    localparam int CARD_FIELD_MAX = (1 << CARD_IN_W) - 1;
    localparam int INDEX_MAX      = (1 << INDEX_W) - 1;
    localparam int CMD_MAX        = (1 << CMD_W) - 1;
    localparam int RANDOM_ITEMS   = 1300;
    // Random rounds clear the store once it holds more than this. Builds then
    // stay short, and only the final fill pays for a long build.
    localparam int ROUND_ITEM_CAP = 48;
    // Number of items stored before the largest build of the run.
    localparam int FILL_ITEMS     = 250;
    // The slowest correct stretch without any handshake is the build of the
    // final fill; the limit is set well above the length of that build.
    localparam int STALL_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 16;

    // Command codes that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic [HAND_W-1:0]    hand;
        logic [CARD_IN_W-1:0] first;
        logic [CARD_IN_W-1:0] second;
        logic [INDEX_W-1:0]   read_pos;
        bit                   known;
        logic [STATUS_W-1:0]  status;
        logic [VALUE_W-1:0]   value;
    } t_opening_row;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
    } t_card_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd;
    logic [HAND_W-1:0]    i_hand_id;
    logic [CARD_IN_W-1:0] i_card_first;
    logic [CARD_IN_W-1:0] i_card_second;
    logic [INDEX_W-1:0]   i_read_index;
    logic                 o_done;
    logic [STATUS_W-1:0]  o_status;
    logic [VALUE_W-1:0]   o_read_value;

    card_holder_list_builder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_hand_id    (i_hand_id),
        .i_card_first (i_card_first),
        .i_card_second(i_card_second),
        .i_read_index (i_read_index),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_value (o_read_value)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the index held by the block.
    logic [HAND_W-1:0] held_ids [MAX_ITEMS];
    int                held_first [MAX_ITEMS];
    int                held_second [MAX_ITEMS];
    int                held_total = 0;
    int                card_tally [NUM_CARDS] = '{default: 0};
    int                bucket_start [NUM_CARDS + 1] = '{default: 0};
    logic [HAND_W-1:0] bucket_ids [LIST_DEPTH];
    bit                index_ready = 1'b0;

    t_card_answer pending_answers [$];

    int  fault_count    = 0;
    int  answers_checked = 0;
    int  commands_sent  = 0;
    int  random_items   = 0;
    int  builds_sent    = 0;
    int  idle_cycles    = 0;
    int  burst_left     = 0;
    bit  sender_live    = 1'b0;
    bit  sender_quiet   = 1'b0;
    bit  in_random_part = 1'b0;

    // The opening table. Rows whose answer is obvious from the rules carry
    // it. The rest, reads of a freshly built index, are left to the
    // model. Covered here: reads before any build, a build of an empty store,
    // offset indices at and beyond the last bucket, the ignored command codes
    // with every field at its maximum, hand ids at both extremes, a card named
    // twice, out-of-range cards in either position, an add after a build, and
    // a clear.
    t_opening_row opening_rows [25] = '{
        '{CMD_READ_OFF,  11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_UNBUILT, 13'd0},
        '{CMD_READ_LIST, 11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_UNBUILT, 13'd0},
        '{CMD_BUILD,     11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_OK,      13'd0},
        '{CMD_READ_OFF,  11'd0,    6'd0,  6'd0,  12'd52,   1'b1, STAT_OK,      13'd0},
        '{CMD_READ_OFF,  11'd0,    6'd0,  6'd0,  12'd53,   1'b1, STAT_RANGE,   13'd0},
        '{CMD_READ_OFF,  11'd0,    6'd0,  6'd0,  12'd4095, 1'b1, STAT_RANGE,   13'd0},
        '{CMD_READ_LIST, 11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_RANGE,   13'd0},
        '{CMD_SPARE5,    11'd2047, 6'd63, 6'd63, 12'd4095, 1'b1, STAT_OK,      13'd0},
        '{CMD_SPARE6,    11'd2047, 6'd63, 6'd63, 12'd4095, 1'b1, STAT_OK,      13'd0},
        '{CMD_SPARE7,    11'd2047, 6'd63, 6'd63, 12'd4095, 1'b1, STAT_OK,      13'd0},
        '{CMD_ADD,       11'd2047, 6'd0,  6'd51, 12'd0,    1'b1, STAT_OK,      13'd0},
        '{CMD_ADD,       11'd0,    6'd51, 6'd51, 12'd0,    1'b1, STAT_OK,      13'd0},
        '{CMD_ADD,       11'd1365, 6'd52, 6'd0,  12'd0,    1'b1, STAT_RANGE,   13'd0},
        '{CMD_ADD,       11'd682,  6'd3,  6'd63, 12'd0,    1'b1, STAT_RANGE,   13'd0},
        '{CMD_READ_OFF,  11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_UNBUILT, 13'd0},
        '{CMD_BUILD,     11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_OK,      13'd4},
        '{CMD_READ_OFF,  11'd0,    6'd0,  6'd0,  12'd52,   1'b0, STAT_OK,      13'd0},
        '{CMD_READ_OFF,  11'd0,    6'd0,  6'd0,  12'd51,   1'b0, STAT_OK,      13'd0},
        '{CMD_READ_LIST, 11'd0,    6'd0,  6'd0,  12'd0,    1'b0, STAT_OK,      13'd0},
        '{CMD_READ_LIST, 11'd0,    6'd0,  6'd0,  12'd3,    1'b0, STAT_OK,      13'd0},
        '{CMD_READ_LIST, 11'd0,    6'd0,  6'd0,  12'd4,    1'b1, STAT_RANGE,   13'd0},
        '{CMD_ADD,       11'd1024, 6'd26, 6'd13, 12'd0,    1'b1, STAT_OK,      13'd0},
        '{CMD_READ_LIST, 11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_UNBUILT, 13'd0},
        '{CMD_CLEAR,     11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_OK,      13'd0},
        '{CMD_READ_OFF,  11'd0,    6'd0,  6'd0,  12'd0,    1'b1, STAT_UNBUILT, 13'd0}
    };

    // Applies one accepted command to the shadow index and returns the
    // answer the block owes for it.
    function automatic t_card_answer card_index_predict(
        input logic [CMD_W-1:0]     cmd,
        input logic [HAND_W-1:0]    hand,
        input logic [CARD_IN_W-1:0] first,
        input logic [CARD_IN_W-1:0] second,
        input logic [INDEX_W-1:0]   read_pos
    );
        t_card_answer answer;
        int           cursor [NUM_CARDS];
        int           c0;
        int           c1;
        answer.cmd    = cmd;
        answer.status = STAT_OK;
        answer.value  = '0;
        c0 = int'(first);
        c1 = int'(second);
        case (cmd)
            CMD_CLEAR: begin
                held_total   = 0;
                card_tally   = '{default: 0};
                bucket_start = '{default: 0};
                index_ready  = 1'b0;
            end
            CMD_ADD: begin
                // A full store is refused before the cards are looked at.
                if (held_total >= MAX_ITEMS) begin
                    answer.status = STAT_FULL;
                end else if (c0 >= NUM_CARDS || c1 >= NUM_CARDS) begin
                    answer.status = STAT_RANGE;
                end else begin
                    held_ids[held_total]    = hand;
                    held_first[held_total]  = c0;
                    held_second[held_total] = c1;
                    held_total++;
                    card_tally[c0]++;
                    card_tally[c1]++;
                    index_ready = 1'b0;
                end
            end
            CMD_BUILD: begin
                bucket_start[0] = 0;
                for (int c = 0; c < NUM_CARDS; c++)
                    bucket_start[c + 1] = bucket_start[c] + card_tally[c];
                for (int c = 0; c < NUM_CARDS; c++)
                    cursor[c] = bucket_start[c];
                // Scatter in arrival order; a card named twice gets the id twice.
                for (int i = 0; i < held_total; i++) begin
                    bucket_ids[cursor[held_first[i]]] = held_ids[i];
                    cursor[held_first[i]]++;
                    bucket_ids[cursor[held_second[i]]] = held_ids[i];
                    cursor[held_second[i]]++;
                end
                index_ready  = 1'b1;
                answer.value = VALUE_W'(bucket_start[NUM_CARDS]);
            end
            CMD_READ_OFF: begin
                if (!index_ready)
                    answer.status = STAT_UNBUILT;
                else if (int'(read_pos) > NUM_CARDS)
                    answer.status = STAT_RANGE;
                else
                    answer.value = VALUE_W'(bucket_start[read_pos]);
            end
            CMD_READ_LIST: begin
                if (!index_ready)
                    answer.status = STAT_UNBUILT;
                else if (int'(read_pos) >= bucket_start[NUM_CARDS])
                    answer.status = STAT_RANGE;
                else
                    answer.value = VALUE_W'(bucket_ids[read_pos]);
            end
            default: begin
                // Spare codes leave the index untouched.
            end
        endcase
        return answer;
    endfunction

    function automatic logic [HAND_W-1:0] any_hand();
        return HAND_W'($urandom_range(0, HAND_MAX));
    endfunction

    function automatic logic [CARD_IN_W-1:0] good_card();
        return CARD_IN_W'($urandom_range(0, NUM_CARDS - 1));
    endfunction

    function automatic logic [CARD_IN_W-1:0] bad_card();
        return CARD_IN_W'($urandom_range(NUM_CARDS, CARD_FIELD_MAX));
    endfunction

    function automatic logic [INDEX_W-1:0] any_pos();
        return INDEX_W'($urandom_range(0, INDEX_MAX));
    endfunction

    // Lowers start, at most once in this time step, and lets cycles pass.
    task automatic hold_sender(input int cycles);
        if (sender_live) begin
            start       <= 1'b0;
            sender_live = 1'b0;
        end
        repeat (cycles) @(posedge i_clk);
    endtask

    // Presents one command, waits for the handshake, queues its answer and
    // then decides whether the sender takes a break. Outside the quiet
    // rounds the sender works in bursts of random length. The breaks between
    // bursts land wherever the block happens to be, including mid-build.
    task automatic issue(
        input logic [CMD_W-1:0]     cmd,
        input logic [HAND_W-1:0]    hand,
        input logic [CARD_IN_W-1:0] first,
        input logic [CARD_IN_W-1:0] second,
        input logic [INDEX_W-1:0]   read_pos,
        input bit                   known = 1'b0,
        input logic [STATUS_W-1:0]  known_status = STAT_OK,
        input logic [VALUE_W-1:0]   known_value = '0
    );
        t_card_answer answer;
        start         <= 1'b1;
        sender_live   = 1'b1;
        i_cmd         <= cmd;
        i_hand_id     <= hand;
        i_card_first  <= first;
        i_card_second <= second;
        i_read_index  <= read_pos;
        do @(posedge i_clk); while (busy);
        // The model is always advanced so that its state follows the block.
        // A typed-in answer, where the row has one, replaces its prediction.
        answer = card_index_predict(cmd, hand, first, second, read_pos);
        if (known) begin
            answer.status = known_status;
            answer.value  = known_value;
        end
        pending_answers = {pending_answers, answer};
        commands_sent++;
        if (in_random_part && cmd <= CMD_READ_LIST)
            random_items++;
        if (cmd == CMD_BUILD)
            builds_sent++;
        if (!sender_quiet) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                hold_sender($urandom_range(1, 9));
            end
        end
    endtask

    // Stops sending until every queued answer has arrived.
    task automatic drain_results();
        hold_sender(1);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // Occasionally slips in a command with every field fully random: spare
    // codes, stray clears and builds, bad cards and wild indices.
    task automatic maybe_noise();
        if ($urandom_range(0, 9) == 0)
            issue(CMD_W'($urandom_range(0, CMD_MAX)), any_hand(),
                  CARD_IN_W'($urandom_range(0, CARD_FIELD_MAX)),
                  CARD_IN_W'($urandom_range(0, CARD_FIELD_MAX)), any_pos());
    endtask

    // One well-formed cycle of use: an optional clear, a handful of adds, a
    // build, and reads that mostly land inside the built index. A few
    // rounds skip the build so that reads meet a stale or unbuilt index.
    task automatic random_round();
        int                 adds;
        int                 reads;
        int                 total;
        logic [INDEX_W-1:0] pos;
        sender_quiet = ($urandom_range(0, 5) == 0);
        if (held_total > ROUND_ITEM_CAP || $urandom_range(0, 3) == 0)
            issue(CMD_CLEAR, any_hand(), good_card(), good_card(), any_pos());
        adds = $urandom_range(0, 12);
        repeat (adds) begin
            maybe_noise();
            case ($urandom_range(0, 15))
                0: issue(CMD_ADD, any_hand(), bad_card(), good_card(), any_pos());
                1: issue(CMD_ADD, any_hand(), good_card(), bad_card(), any_pos());
                default: issue(CMD_ADD, any_hand(), good_card(), good_card(), any_pos());
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            drain_results();
        if ($urandom_range(0, 11) != 0)
            issue(CMD_BUILD, any_hand(), good_card(), good_card(), any_pos());
        reads = $urandom_range(2, 14);
        repeat (reads) begin
            maybe_noise();
            total = bucket_start[NUM_CARDS];
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 9) == 0)
                    pos = any_pos();
                else
                    pos = INDEX_W'($urandom_range(0, NUM_CARDS));
                issue(CMD_READ_OFF, any_hand(), good_card(), good_card(), pos);
            end else begin
                if (total == 0 || $urandom_range(0, 9) == 0)
                    pos = any_pos();
                else
                    pos = INDEX_W'($urandom_range(0, total - 1));
                issue(CMD_READ_LIST, any_hand(), good_card(), good_card(), pos);
            end
        end
    endtask

    // Fills the store with FILL_ITEMS items, offers an add with two bad cards,
    // builds the largest index of the run and reads across it up to the last
    // offset and list position, then clears and reads the unbuilt index.
    task automatic fill_store();
        int total;
        sender_quiet = 1'b0;
        issue(CMD_CLEAR, any_hand(), good_card(), good_card(), any_pos());
        while (held_total < FILL_ITEMS)
            issue(CMD_ADD, any_hand(), good_card(), good_card(), any_pos());
        issue(CMD_ADD, any_hand(), bad_card(), bad_card(), any_pos());
        issue(CMD_BUILD, any_hand(), good_card(), good_card(), any_pos());
        total = bucket_start[NUM_CARDS];
        issue(CMD_READ_OFF, any_hand(), good_card(), good_card(), INDEX_W'(NUM_CARDS));
        issue(CMD_READ_LIST, any_hand(), good_card(), good_card(), INDEX_W'(total - 1));
        repeat (40) begin
            if ($urandom_range(0, 3) == 0)
                issue(CMD_READ_OFF, any_hand(), good_card(), good_card(),
                      INDEX_W'($urandom_range(0, NUM_CARDS)));
            else
                issue(CMD_READ_LIST, any_hand(), good_card(), good_card(),
                      INDEX_W'($urandom_range(0, total - 1)));
        end
        issue(CMD_CLEAR, any_hand(), good_card(), good_card(), any_pos());
        issue(CMD_READ_LIST, any_hand(), good_card(), good_card(), '0);
    endtask

    // Result checker. Every strobed result must have an answer waiting.
    always @(posedge i_clk) begin
        t_card_answer want;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, status %0d value %0d",
                         $time, o_status, o_read_value);
                fault_count++;
            end else begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (o_status !== want.status) begin
                    $display("%0t: cmd %0d status expected %0d got %0d",
                             $time, want.cmd, want.status, o_status);
                    fault_count++;
                end
                if (o_read_value !== want.value) begin
                    $display("%0t: cmd %0d read_value expected %0d got %0d",
                             $time, want.cmd, want.value, o_read_value);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog: any handshake or result counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cmd         <= CMD_CLEAR;
        i_hand_id     <= '0;
        i_card_first  <= '0;
        i_card_second <= '0;
        i_read_index  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening, sent back to back with the usual bursts.
        foreach (opening_rows[r])
            issue(opening_rows[r].cmd, opening_rows[r].hand, opening_rows[r].first,
                  opening_rows[r].second, opening_rows[r].read_pos,
                  opening_rows[r].known, opening_rows[r].status, opening_rows[r].value);

        in_random_part = 1'b1;
        while (random_items < RANDOM_ITEMS)
            random_round();
        in_random_part = 1'b0;

        // Make sure the sender waits out every answer at least once.
        drain_results();
        fill_store();

        hold_sender(1);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d commands, %0d results checked, %0d builds, %0d mismatches.",
                 commands_sent, answers_checked, builds_sent, fault_count);
        $display("Covered the corner table, %0d random commands and a %0d-item build.",
                 random_items, FILL_ITEMS);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
